/* rtl/core/tqla_pkg.sv */
package tqla_pkg;

  localparam int NUM_BINS     = 16;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int ACTION_COUNT = 9;
  localparam int DEPTH        = NUM_BINS * ACTION_COUNT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_ACT     = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ALPHA   = 2'd0,
    CFG_GAMMA   = 2'd1,
    CFG_EPSILON = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_MUL1, S_DIFF, S_MUL2, S_WRITE
  } back_state_e;

  // classified item handed from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic [BIN_W-1:0]   bin_a;    // act bin or update bin_now
    logic [BIN_W-1:0]   bin_b;    // bootstrap row for update
    logic [3:0]         action;   // clamped action / random action
    logic               explore;
    logic signed [31:0] reward;
    logic               done;
  } item_t;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [1:0]  bid;
    logic signed [1:0]  ask;
    logic signed [31:0] new_q;
    logic               written;
  } result_t;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [3:0] b);
    logic [31:0] w;
    w = 32'(b);
    if (w > 32'(NUM_BINS - 1)) w = 32'(NUM_BINS - 1);
    return w[BIN_W-1:0];
  endfunction

  function automatic logic [3:0] clamp_action(input logic [3:0] a);
    return (a > 4'(ACTION_COUNT - 1)) ? 4'(ACTION_COUNT - 1) : a;
  endfunction

  // action div 3 minus 1
  function automatic logic signed [1:0] bid_of(input logic [3:0] a);
    if (a < 4'd3) return -2'sd1;
    else if (a < 4'd6) return 2'sd0;
    else return 2'sd1;
  endfunction

  // action mod 3 minus 1
  function automatic logic signed [1:0] ask_of(input logic [3:0] a);
    logic signed [1:0] r;
    unique case (a)
      4'd0, 4'd3, 4'd6: r = -2'sd1;
      4'd1, 4'd4, 4'd7: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/tqla_front.sv */
module tqla_front (
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic signed [15:0]     position_norm_i,
  input  logic [15:0]            rand_draw_i,
  input  logic [3:0]             rand_action_i,
  input  logic signed [31:0]     reward_i,
  input  logic                   episode_done_i,
  input  logic [3:0]             bin_now_i,
  input  logic [3:0]             action_index_i,
  input  logic [3:0]             bin_next_i,
  input  logic [15:0]            epsilon_i,
  input  logic                   full_i,
  output logic                   push_o,
  output tqla_pkg::item_t        item_o
);

  logic [15:0]                      shifted;
  logic [16+tqla_pkg::BIN_W-1:0]    bin_prod;
  tqla_pkg::cmd_e                   cmd;

  // inventory feature to bin: (pos + 32768) * (bins - 1) >> 16
  assign shifted  = {~position_norm_i[15], position_norm_i[14:0]};
  assign bin_prod = (16+tqla_pkg::BIN_W)'(shifted)
                  * (16+tqla_pkg::BIN_W)'(tqla_pkg::NUM_BINS - 1);
  assign cmd      = tqla_pkg::cmd_e'(cmd_i);

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  // classify by command
  always_comb begin
    item_o         = '0;
    item_o.cmd     = cmd;
    item_o.reward  = reward_i;
    item_o.done    = episode_done_i;
    unique case (cmd)
      tqla_pkg::CMD_ACT: begin
        item_o.bin_a   = bin_prod[16 +: tqla_pkg::BIN_W];
        item_o.action  = tqla_pkg::clamp_action(rand_action_i);
        item_o.explore = rand_draw_i < epsilon_i;
      end
      tqla_pkg::CMD_UPDATE: begin
        item_o.bin_a  = tqla_pkg::clamp_bin(bin_now_i);
        item_o.bin_b  = tqla_pkg::clamp_bin(bin_next_i);
        item_o.action = tqla_pkg::clamp_action(action_index_i);
        item_o.done   = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/tqla_queue.sv */
module tqla_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tqla_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tqla_pkg::item_t item_o
);

  localparam int PW = (tqla_pkg::QUEUE_DEPTH > 1) ? $clog2(tqla_pkg::QUEUE_DEPTH) : 1;

  tqla_pkg::item_t                             mem_q [tqla_pkg::QUEUE_DEPTH];
  logic [PW-1:0]                               wr_q, rd_q;
  logic [$clog2(tqla_pkg::QUEUE_DEPTH+1)-1:0]  cnt_q;

  assign full_o  = cnt_q == ($bits(cnt_q))'(tqla_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(tqla_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(tqla_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + ($bits(cnt_q))'(push_i) - ($bits(cnt_q))'(pop_i);
    end
  end

endmodule

/* rtl/core/tqla_back.sv */
module tqla_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tqla_pkg::item_t      item_i,
  output logic                 pop_o,
  input  logic [15:0]          alpha_i,
  input  logic [15:0]          gamma_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output tqla_pkg::result_t    res_o
);

  localparam int AW = tqla_pkg::ADDR_W;
  localparam int BW = tqla_pkg::BIN_W;

  tqla_pkg::back_state_e state_q, state_d;

  tqla_pkg::item_t       item_q;
  logic [3:0]            cnt_q;
  logic [BW-1:0]         scan_row_q, tgt_row_q;
  logic [3:0]            tgt_act_q;
  logic [BW-1:0]         last_bin_q;
  logic [3:0]            last_act_q;
  logic                  have_prev_q;

  logic signed [31:0]    max_q, qold_q;
  logic [3:0]            arg_q;
  logic signed [48:0]    prod1_q;
  logic signed [34:0]    diff_q;
  logic signed [51:0]    prod2_q;

  logic                  res_valid_q;
  tqla_pkg::result_t     res_q;

  // table memory with per-entry valid bits
  logic [31:0]           mem [tqla_pkg::DEPTH];
  logic                  vld_q [tqla_pkg::DEPTH];
  logic [31:0]           rd_data_q;
  logic                  rd_vld_q, rd_pend_q;
  logic [3:0]            rd_tag_q;
  logic signed [31:0]    rd_val;

  logic                  pop, rd_en, we, is_act, last_scan;
  logic [AW-1:0]         raddr, waddr;
  logic signed [48:0]    sum1;
  logic signed [31:0]    scaled;
  logic signed [33:0]    target;
  logic signed [51:0]    sum2;
  logic signed [35:0]    step;
  logic signed [36:0]    nq_wide;
  logic signed [31:0]    nq;
  logic [3:0]            act_pick;

  assign is_act    = item_q.cmd == tqla_pkg::CMD_ACT;
  assign last_scan = is_act ? (cnt_q == 4'(tqla_pkg::ACTION_COUNT - 1))
                            : (cnt_q == 4'(tqla_pkg::ACTION_COUNT));
  assign raddr = (cnt_q < 4'(tqla_pkg::ACTION_COUNT))
               ? AW'(scan_row_q) * AW'(tqla_pkg::ACTION_COUNT) + AW'(cnt_q)
               : AW'(tgt_row_q) * AW'(tqla_pkg::ACTION_COUNT) + AW'(tgt_act_q);
  assign waddr = AW'(tgt_row_q) * AW'(tqla_pkg::ACTION_COUNT) + AW'(tgt_act_q);
  assign rd_val = rd_vld_q ? $signed(rd_data_q) : 32'sd0;

  // rounding products: add half, floor shift
  assign sum1    = prod1_q + 49'sd32768;
  assign scaled  = sum1[47:16];
  assign target  = 34'(item_q.reward) + ((item_q.done) ? 34'sd0 : 34'(scaled));
  assign sum2    = prod2_q + 52'sd32768;
  assign step    = sum2[51:16];
  assign nq_wide = 37'(qold_q) + 37'(step);
  assign act_pick = item_q.explore ? item_q.action : arg_q;

  always_comb begin
    if (nq_wide > 37'sh07FFFFFFF)       nq = 32'sh7FFFFFFF;
    else if (nq_wide < -37'sh080000000) nq = -32'sh80000000;
    else                                nq = nq_wide[31:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    rd_en   = 1'b0;
    we      = 1'b0;
    unique case (state_q)
      tqla_pkg::S_IDLE: begin
        if (valid_i && !res_valid_q) begin
          pop = 1'b1;
          unique case (item_i.cmd)
            tqla_pkg::CMD_ACT, tqla_pkg::CMD_UPDATE: state_d = tqla_pkg::S_SCAN;
            tqla_pkg::CMD_OBSERVE: if (have_prev_q) state_d = tqla_pkg::S_SCAN;
            default: ;
          endcase
        end
      end
      tqla_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (last_scan) state_d = tqla_pkg::S_DRAIN;
      end
      tqla_pkg::S_DRAIN: state_d = tqla_pkg::S_MUL1;
      tqla_pkg::S_MUL1:  state_d = is_act ? tqla_pkg::S_IDLE : tqla_pkg::S_DIFF;
      tqla_pkg::S_DIFF:  state_d = tqla_pkg::S_MUL2;
      tqla_pkg::S_MUL2:  state_d = tqla_pkg::S_WRITE;
      tqla_pkg::S_WRITE: begin
        we      = 1'b1;
        state_d = tqla_pkg::S_IDLE;
      end
      default: state_d = tqla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tqla_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // memory array
  always_ff @(posedge clk_i) begin
    if (we)    mem[waddr] <= nq;
    if (rd_en) rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tqla_pkg::DEPTH; i++) vld_q[i] <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_tag_q  <= '0;
    end else begin
      if (we) vld_q[waddr] <= 1'b1;
      rd_pend_q <= rd_en;
      if (rd_en) begin
        rd_vld_q <= vld_q[raddr];
        rd_tag_q <= cnt_q;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= item_i;
      unique case (item_i.cmd)
        tqla_pkg::CMD_ACT: scan_row_q <= item_i.bin_a;
        tqla_pkg::CMD_UPDATE: begin
          scan_row_q <= item_i.bin_b;
          tgt_row_q  <= item_i.bin_a;
          tgt_act_q  <= item_i.action;
        end
        default: begin
          scan_row_q <= last_bin_q;
          tgt_row_q  <= last_bin_q;
          tgt_act_q  <= last_act_q;
        end
      endcase
    end
    // row maximum, first index wins ties
    if (rd_pend_q) begin
      if (rd_tag_q == 4'(tqla_pkg::ACTION_COUNT)) begin
        qold_q <= rd_val;
      end else if (rd_tag_q == 4'd0 || rd_val > max_q) begin
        max_q <= rd_val;
        arg_q <= rd_tag_q;
      end
    end
    if (state_q == tqla_pkg::S_MUL1) prod1_q <= max_q * $signed({1'b0, gamma_i});
    if (state_q == tqla_pkg::S_DIFF) diff_q  <= 35'(target) - 35'(qold_q);
    if (state_q == tqla_pkg::S_MUL2) prod2_q <= diff_q * $signed({1'b0, alpha_i});
  end

  // control: scan counter, episode memory, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_bin_q  <= '0;
      last_act_q  <= '0;
      have_prev_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (pop)        cnt_q <= '0;
      else if (rd_en) cnt_q <= cnt_q + 4'd1;
      // a new result is only made while none is waiting
      if (pop && state_d == tqla_pkg::S_IDLE) begin
        res_valid_q <= 1'b1;
        res_q       <= '0;
      end else if (state_q == tqla_pkg::S_MUL1 && is_act) begin
        res_valid_q <= 1'b1;
        res_q       <= '{action: act_pick, bid: tqla_pkg::bid_of(act_pick),
                         ask: tqla_pkg::ask_of(act_pick), new_q: 32'sd0,
                         written: 1'b0};
        last_bin_q  <= scan_row_q;
        last_act_q  <= act_pick;
        have_prev_q <= 1'b1;
      end else if (we) begin
        res_valid_q <= 1'b1;
        res_q       <= '{action: 4'd0, bid: 2'sd0, ask: 2'sd0, new_q: nq,
                         written: 1'b1};
        if (item_q.cmd == tqla_pkg::CMD_OBSERVE && item_q.done) have_prev_q <= 1'b0;
      end else if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign pop_o       = pop;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (state_q == tqla_pkg::S_IDLE) && !res_valid_q)
    else $error("item taken while busy");
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> res_valid_q && res_q.written)
    else $error("table write without result");
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !res_valid_q && !rd_en)
    else $error("write overlaps pending result or read");
  a_scan_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tqla_pkg::S_DRAIN) |-> rd_pend_q)
    else $error("scan data missing at drain");
`endif

endmodule

/* rtl/core/tabular_q_learning_agent_unit.sv */
// Q-learning agent with epsilon-greedy choice over a 16 x 9 Q16.16 table.
// Act: the row scan (SCAN, DRAIN) and then MUL1 give the result; observe/update add DIFF, MUL2
// and WRITE; observe without history and unused commands answer straight from IDLE with a zero result.
// One item in the back end at a time, taken only once the previous result has been transferred;
// the queue in front keeps accepting input transfers while the back end is busy, until it is full.
// Reset (rst_ni low, async): table reads as zero, history cleared, registers to defaults.
module tabular_q_learning_agent_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: position_norm[15:0], rand_draw[31:16], rand_action[35:32],
  //        reward[67:36], bin_now[71:68], action_index[75:72], bin_next[79:76]
  input  logic [79:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,     // episode_done
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: chosen_action[3:0], bid_tick[5:4], ask_tick[7:6], new_q[39:8]
  output logic [39:0]  m_axis_tdata,
  // tuser: entry_written[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0]        alpha_q, gamma_q, epsilon_q;
  logic               push, full, q_valid, pop;
  tqla_pkg::item_t    item_in, item_out;
  tqla_pkg::result_t  res;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= 16'd6554;
      gamma_q   <= 16'd62259;
      epsilon_q <= 16'd6554;
    end else if (cfg_valid_i) begin
      unique case (tqla_pkg::cfg_reg_e'(cfg_index_i))
        tqla_pkg::CFG_ALPHA:   alpha_q   <= cfg_data_i;
        tqla_pkg::CFG_GAMMA:   gamma_q   <= cfg_data_i;
        tqla_pkg::CFG_EPSILON: epsilon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tqla_front u_front (
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .cmd_i           (s_axis_tuser),
    .position_norm_i (s_axis_tdata[15:0]),
    .rand_draw_i     (s_axis_tdata[31:16]),
    .rand_action_i   (s_axis_tdata[35:32]),
    .reward_i        (s_axis_tdata[67:36]),
    .episode_done_i  (s_axis_tlast),
    .bin_now_i       (s_axis_tdata[71:68]),
    .action_index_i  (s_axis_tdata[75:72]),
    .bin_next_i      (s_axis_tdata[79:76]),
    .epsilon_i       (epsilon_q),
    .full_i          (full),
    .push_o          (push),
    .item_o          (item_in)
  );

  tqla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (item_out)
  );

  tqla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (item_out),
    .pop_o       (pop),
    .alpha_i     (alpha_q),
    .gamma_i     (gamma_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.new_q, res.ask, res.bid, res.action};
  assign m_axis_tuser = res.written;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int RAND_ITEMS = 500;
  localparam int Q_ROWS     = 16;
  localparam int N_ACT      = 9;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  tabular_q_learning_agent_unit dut (.*);

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        done;
    logic [79:0] data;
  } agent_cmd_t;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [1:0]  bid;
    logic signed [1:0]  ask;
    logic signed [31:0] new_q;
    logic               written;
  } agent_out_t;

  agent_cmd_t pending_cmds[$];
  agent_out_t expected_outs[$];

  // predictor state
  logic signed [31:0] q_tab [Q_ROWS*N_ACT];
  logic [3:0]  mem_bin, mem_act;
  logic        mem_valid;
  logic [15:0] alpha_r, gamma_r, eps_r;

  int  n_errors = 0;
  bit  quiet = 0;     // no idling in the last part
  bit  in_fired = 0;  // input transfer at the last rising edge
  int  in_gap = 0, out_gap = 0;

  function automatic longint scale_frac(longint v, logic [15:0] f);
    longint p;
    p = v * longint'({1'b0, f}) + 32768;
    return p >>> 16;   // arithmetic shift = floor
  endfunction

  function automatic logic signed [31:0] sat_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] best_q(int row);
    logic signed [31:0] b;
    b = q_tab[row*N_ACT];
    for (int a = 1; a < N_ACT; a++) if (q_tab[row*N_ACT+a] > b) b = q_tab[row*N_ACT+a];
    return b;
  endfunction

  function automatic logic signed [31:0] learn(int row, int a, longint tgt);
    longint q;
    q = q_tab[row*N_ACT+a];
    q_tab[row*N_ACT+a] = sat_q(q + scale_frac(tgt - q, alpha_r));
    return q_tab[row*N_ACT+a];
  endfunction

  task automatic predict_agent(input agent_cmd_t c);
    agent_out_t o;
    longint rw, tgt;
    int bin, a, sb, sn;
    logic [15:0] pos;
    o = '0;
    rw = longint'($signed(c.data[67:36]));
    case (tqla_pkg::cmd_e'(c.cmd))
      tqla_pkg::CMD_ACT: begin
        pos = c.data[15:0] ^ 16'h8000;
        bin = (int'(pos) * (Q_ROWS - 1)) >> 16;
        if (c.data[31:16] < eps_r) begin
          a = (c.data[35:32] > 4'd8) ? 8 : int'(c.data[35:32]);
        end else begin
          a = 0;
          for (int k = 1; k < N_ACT; k++)
            if (q_tab[bin*N_ACT+k] > q_tab[bin*N_ACT+a]) a = k;
        end
        mem_bin = 4'(bin); mem_act = 4'(a); mem_valid = 1;
        o.action = 4'(a);
        o.bid = 2'(a / 3 - 1);
        o.ask = 2'(a % 3 - 1);
      end
      tqla_pkg::CMD_OBSERVE: begin
        if (mem_valid) begin
          tgt = rw;
          if (!c.done) tgt += scale_frac(best_q(int'(mem_bin)), gamma_r);
          o.new_q = learn(int'(mem_bin), int'(mem_act), tgt);
          o.written = 1;
          if (c.done) mem_valid = 0;
        end
      end
      tqla_pkg::CMD_UPDATE: begin
        sb = int'(c.data[71:68]);
        a = (c.data[75:72] > 4'd8) ? 8 : int'(c.data[75:72]);
        sn = int'(c.data[79:76]);
        tgt = rw + scale_frac(best_q(sn), gamma_r);
        o.new_q = learn(sb, a, tgt);
        o.written = 1;
      end
      default: ;
    endcase
    expected_outs.push_back(o);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fired) begin
        in_fired = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_cmds[0].cmd;
          s_axis_tlast <= pending_cmds[0].done;
          s_axis_tdata <= pending_cmds[0].data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      // output stall bursts
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // accept and predict at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      in_fired = 1'b1;
      predict_agent(pending_cmds.pop_front());
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    agent_out_t got, exp_o;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action = m_axis_tdata[3:0];
      got.bid = m_axis_tdata[5:4];
      got.ask = m_axis_tdata[7:6];
      got.new_q = m_axis_tdata[39:8];
      got.written = m_axis_tuser;
      if (expected_outs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_o = expected_outs.pop_front();
        if (got !== exp_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                     exp_o.action, exp_o.bid, exp_o.ask, exp_o.new_q, exp_o.written,
                     got.action, got.bid, got.ask, got.new_q, got.written);
        end
      end
    end
  end

  task automatic add_cmd(input tqla_pkg::cmd_e c, input logic [15:0] pos,
                         input logic [15:0] draw, input logic [3:0] ra,
                         input logic [31:0] rw, input logic dn, input logic [3:0] bn,
                         input logic [3:0] ai, input logic [3:0] bx);
    agent_cmd_t it;
    it.cmd = c;
    it.done = dn;
    it.data = {bx, ai, bn, rw, ra, draw, pos};
    pending_cmds.push_back(it);
  endtask

  task automatic add_random(input bit wild);
    logic [31:0] rw;
    rw = $urandom();
    if (!wild) rw = $signed(rw) >>> $urandom_range(4, 14);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_cmd(tqla_pkg::CMD_ACT, 16'($urandom()), 16'($urandom()),
                          4'($urandom_range(0, 15)), $urandom(), 1'($urandom()),
                          4'($urandom()), 4'($urandom()), 4'($urandom()));
      4, 5, 6:    add_cmd(tqla_pkg::CMD_OBSERVE, 16'($urandom()), 16'($urandom()),
                          4'($urandom()), rw, $urandom_range(0, 3) == 0,
                          4'($urandom()), 4'($urandom()), 4'($urandom()));
      7, 8:       add_cmd(tqla_pkg::CMD_UPDATE, 16'($urandom()), 16'($urandom()),
                          4'($urandom()), rw, 1'($urandom()),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
      default:    add_cmd(tqla_pkg::CMD_NONE, 16'($urandom()), 16'($urandom()),
                          4'($urandom()), $urandom(), 1'($urandom()),
                          4'($urandom()), 4'($urandom()), 4'($urandom()));
    endcase
  endtask

  task automatic drain_all();
    while (pending_cmds.size() > 0 || expected_outs.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input tqla_pkg::cfg_reg_e r, input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (r)
      tqla_pkg::CFG_ALPHA:   alpha_r = v;
      tqla_pkg::CFG_GAMMA:   gamma_r = v;
      tqla_pkg::CFG_EPSILON: eps_r = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < Q_ROWS*N_ACT; i++) q_tab[i] = 0;
    mem_bin = 0; mem_act = 0; mem_valid = 0;
    alpha_r = 6554; gamma_r = 62259; eps_r = 6554;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: observe before any act, extremes, ties, clamps, unused command
    add_cmd(tqla_pkg::CMD_OBSERVE, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_ACT, 16'h8000, 16'hffff, 0, 0, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_OBSERVE, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_ACT, 16'h7fff, 16'h0000, 4'hf, 0, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_OBSERVE, 0, 0, 0, 32'h8000_0000, 1, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_OBSERVE, 0, 0, 0, 32'h1234_5678, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_UPDATE, 0, 0, 0, 32'h7fff_ffff, 0, 4'hf, 4'hf, 4'hf);
    add_cmd(tqla_pkg::CMD_UPDATE, 0, 0, 0, 32'h8000_0000, 0, 4'h0, 4'h0, 4'h0);
    add_cmd(tqla_pkg::CMD_UPDATE, 0, 0, 0, 32'hffff_ffff, 1, 4'h3, 4'h9, 4'h0);
    add_cmd(tqla_pkg::CMD_ACT, 16'h0000, 16'hffff, 0, 0, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_OBSERVE, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_ACT, 16'hffff, 16'h0001, 4'h8, 0, 0, 0, 0, 0);
    add_cmd(tqla_pkg::CMD_NONE, 16'hffff, 16'hffff, 4'hf, 32'hffff_ffff, 1,
            4'hf, 4'hf, 4'hf);
    for (int a = 0; a < 9; a++)
      add_cmd(tqla_pkg::CMD_ACT, 16'($urandom()), 0, 4'(a), 0, 0, 0, 0, 0);
    drain_all();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(tqla_pkg::CFG_ALPHA, 16'hffff);
                 write_reg(tqla_pkg::CFG_GAMMA, 16'hffff);
                 write_reg(tqla_pkg::CFG_EPSILON, 16'h0000); end
        1: begin write_reg(tqla_pkg::CFG_ALPHA, 16'h0000);
                 write_reg(tqla_pkg::CFG_GAMMA, 16'h0000);
                 write_reg(tqla_pkg::CFG_EPSILON, 16'hffff); end
        2: begin write_reg(tqla_pkg::CFG_ALPHA, 16'h8000);
                 write_reg(tqla_pkg::CFG_GAMMA, 16'hf333);
                 write_reg(tqla_pkg::CFG_EPSILON, 16'h4000); end
        default: begin write_reg(tqla_pkg::CFG_ALPHA, 16'($urandom()));
                       write_reg(tqla_pkg::CFG_GAMMA, 16'($urandom()));
                       write_reg(tqla_pkg::CFG_EPSILON, 16'($urandom())); end
      endcase
      if (ph == 4) quiet = 1;
      for (int i = 0; i < RAND_ITEMS/5; i++) add_random($urandom_range(0, 3) == 0);
      drain_all();
    end

    if (n_errors == 0) begin
      $display("[tabular_q_learning_agent_unit] OK");
    end else begin
      $display("[tabular_q_learning_agent_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("[tabular_q_learning_agent_unit] ERROR");
    $finish;
  end

endmodule
